// ===== src/rtae_pkg.sv =====
// Shared types for the route table with age based eviction.
// Holds the operation codes and the controller/datapath handshake structs.
// No dependencies.
package rtae_pkg;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_EXPIRE = 2'd3
    } t_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;   // latch a new operation and reset the scan trackers
        logic issue;   // read the entry at the scan index
        logic commit;  // apply the table update and present the result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic issue_last;  // the scan index points at the last slot
    } t_stat;

endpackage

// ===== src/rtae_ctrl.sv =====
// Controller state machine for the route table: accept, scan, drain, commit.
// Depends on rtae_pkg for the command and status structs.
module rtae_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  rtae_pkg::t_stat i_stat,
    output rtae_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_busy;

    always_comb begin
        o_cmd.start  = i_start && !r_busy;
        o_cmd.issue  = (r_state == S_SCAN);
        o_cmd.commit = (r_state == S_DONE);
    end

    assign o_busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE, S_DONE: begin
                    if (i_start) begin
                        r_state <= S_SCAN;
                        r_busy  <= 1'b1;
                    end else begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (i_stat.issue_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // The last entry is evaluated in this cycle.
                    r_state <= S_DONE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    a_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("busy disagrees with controller state");

    a_start_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> r_state == S_SCAN)
        else $error("accepted operation did not enter the scan");

endmodule

// ===== src/rtae_dpath.sv =====
// Datapath for the route table: entry memory, valid bits, scan stage and result registers.
// Depends on rtae_pkg for operation codes and the controller command/status structs.
module rtae_dpath #(
    parameter int ROUTE_ENTRIES = 32,
    parameter int ADDR_BITS     = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rtae_pkg::t_cmd  i_cmd,
    output rtae_pkg::t_stat o_stat,
    input  logic [1:0]      i_op,
    input  logic [15:0]     i_dest_addr,
    input  logic [15:0]     i_hop_addr,
    input  logic [15:0]     i_link_cost,
    input  logic [7:0]      i_hop_count,
    input  logic [31:0]     i_time_now,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [31:0]     i_cfg_data,
    output logic            o_done,
    output logic            o_hit,
    output logic [15:0]     o_found_next_hop,
    output logic [15:0]     o_found_cost,
    output logic [7:0]      o_found_hops,
    output logic [4:0]      o_slot_index,
    output logic [5:0]      o_removed_count,
    output logic [5:0]      o_entry_count
);

    localparam int IW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int CW = $clog2(ROUTE_ENTRIES + 1);
    localparam logic [31:0] TIMEOUT_RESET = 32'd300000;

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [IW-1:0]        t_idx;
    typedef logic [CW-1:0]        t_cnt;

    typedef struct packed {
        t_addr       dest;
        t_addr       via;
        logic [15:0] cost;
        logic [7:0]  hops;
        logic [31:0] stamp;
    } t_entry;

    // Entry memory: one write port at commit, one registered read port for the scan.
    t_entry r_mem [ROUTE_ENTRIES];
    t_entry r_q;

    logic [ROUTE_ENTRIES-1:0] r_valid;
    logic [31:0]  r_timeout;
    t_cnt         r_live;

    // Latched operation.
    rtae_pkg::t_op r_op;
    t_addr        r_dst;
    t_addr        r_nh;
    logic [15:0]  r_cost;
    logic [7:0]   r_hops;
    logic [31:0]  r_now;

    // Scan pipeline and trackers.
    t_idx         r_idx;
    t_idx         r_q_idx;
    logic         r_q_ok;
    logic         r_found;
    logic         r_hit;
    t_idx         r_slot;
    logic         r_have_free;
    t_idx         r_free;
    t_idx         r_old;
    logic [31:0]  r_max_age;
    t_cnt         r_drop;
    t_addr        r_f_nh;
    logic [15:0]  r_f_cost;
    logic [7:0]   r_f_hops;

    // Result registers.
    logic         r_done;
    logic         r_o_hit;
    logic [15:0]  r_o_nh;
    logic [15:0]  r_o_cost;
    logic [7:0]   r_o_hops;
    logic [4:0]   r_o_slot;
    logic [5:0]   r_o_removed;
    logic [5:0]   r_o_count;

    logic         n_v;
    logic         n_dest_match;
    logic         n_hop_match;
    logic [31:0]  n_age;
    logic         n_aged;
    t_idx         n_wslot;
    t_cnt         n_live;
    t_entry       n_word;

    assign o_stat.issue_last = (r_idx == t_idx'(ROUTE_ENTRIES - 1));
    assign o_cfg_ready       = 1'b1;

    always_comb begin
        n_v          = r_valid[r_q_idx];
        n_dest_match = (r_q.dest == r_dst);
        n_hop_match  = (r_q.via == r_nh);
        n_age        = r_now - r_q.stamp;
        n_aged       = (n_age > r_timeout);

        if (r_found) begin
            n_wslot = r_slot;
        end else if (r_have_free) begin
            n_wslot = r_free;
        end else begin
            n_wslot = r_old;
        end

        // Floor at zero when removing entries from the live count.
        n_live = (r_drop > r_live) ? '0 : (r_live - r_drop);
        if (r_op == rtae_pkg::OP_ADD && !r_found && r_have_free) begin
            n_live = n_live + t_cnt'(1);
        end

        n_word.dest  = r_dst;
        n_word.via   = r_nh;
        n_word.cost  = r_cost;
        n_word.hops  = r_hops;
        n_word.stamp = r_now;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_q <= r_mem[r_idx];
        end
        if (i_cmd.commit && r_op == rtae_pkg::OP_ADD) begin
            r_mem[n_wslot] <= n_word;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op   <= rtae_pkg::t_op'(i_op);
            r_dst  <= t_addr'(i_dest_addr);
            r_nh   <= t_addr'(i_hop_addr);
            r_cost <= i_link_cost;
            r_hops <= i_hop_count;
            r_now  <= i_time_now;
        end
        if (i_cmd.issue) begin
            r_q_idx <= r_idx;
        end
        if (r_q_ok && r_op == rtae_pkg::OP_LOOKUP && !r_found && n_v && n_dest_match) begin
            r_f_nh   <= r_q.via;
            r_f_cost <= r_q.cost;
            r_f_hops <= r_q.hops;
        end
        if (i_cmd.commit) begin
            unique case (r_op)
                rtae_pkg::OP_LOOKUP: begin
                    r_o_hit     <= r_hit;
                    r_o_nh      <= r_hit ? 16'(r_f_nh) : '0;
                    r_o_cost    <= r_hit ? r_f_cost : '0;
                    r_o_hops    <= r_hit ? r_f_hops : '0;
                    r_o_slot    <= r_hit ? 5'(r_slot) : '0;
                    r_o_removed <= '0;
                end
                rtae_pkg::OP_ADD: begin
                    r_o_hit     <= 1'b1;
                    r_o_nh      <= 16'(r_nh);
                    r_o_cost    <= r_cost;
                    r_o_hops    <= r_hops;
                    r_o_slot    <= 5'(n_wslot);
                    r_o_removed <= '0;
                end
                rtae_pkg::OP_REMOVE, rtae_pkg::OP_EXPIRE: begin
                    r_o_hit     <= 1'b0;
                    r_o_nh      <= '0;
                    r_o_cost    <= '0;
                    r_o_hops    <= '0;
                    r_o_slot    <= '0;
                    r_o_removed <= 6'(r_drop);
                end
                default: begin
                    r_o_hit     <= 1'b0;
                    r_o_nh      <= '0;
                    r_o_cost    <= '0;
                    r_o_hops    <= '0;
                    r_o_slot    <= '0;
                    r_o_removed <= '0;
                end
            endcase
            r_o_count <= 6'(n_live);
        end
    end

    // Control state: valid bits, live count, scan trackers and the result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_live      <= '0;
            r_timeout   <= TIMEOUT_RESET;
            r_idx       <= '0;
            r_q_ok      <= 1'b0;
            r_found     <= 1'b0;
            r_hit       <= 1'b0;
            r_slot      <= '0;
            r_have_free <= 1'b0;
            r_free      <= '0;
            r_old       <= '0;
            r_max_age   <= '0;
            r_drop      <= '0;
            r_done      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end

            r_q_ok <= i_cmd.issue;
            r_done <= i_cmd.commit;

            if (i_cmd.issue) begin
                r_idx <= r_idx + t_idx'(1);
            end

            if (r_q_ok) begin
                unique case (r_op)
                    rtae_pkg::OP_LOOKUP: begin
                        // Only the first valid match counts; an aged one is dropped.
                        if (!r_found && n_v && n_dest_match) begin
                            r_found <= 1'b1;
                            if (n_aged) begin
                                r_valid[r_q_idx] <= 1'b0;
                                r_drop           <= r_drop + t_cnt'(1);
                            end else begin
                                r_hit  <= 1'b1;
                                r_slot <= r_q_idx;
                            end
                        end
                    end
                    rtae_pkg::OP_ADD: begin
                        if (!r_found && n_v && n_dest_match) begin
                            r_found <= 1'b1;
                            r_slot  <= r_q_idx;
                        end
                        if (!n_v && !r_have_free) begin
                            r_have_free <= 1'b1;
                            r_free      <= r_q_idx;
                        end
                        // Ties go to the later slot.
                        if (n_v && n_age >= r_max_age) begin
                            r_max_age <= n_age;
                            r_old     <= r_q_idx;
                        end
                    end
                    rtae_pkg::OP_REMOVE: begin
                        if (n_v && n_hop_match) begin
                            r_valid[r_q_idx] <= 1'b0;
                            r_drop           <= r_drop + t_cnt'(1);
                        end
                    end
                    rtae_pkg::OP_EXPIRE: begin
                        if (n_v && n_aged) begin
                            r_valid[r_q_idx] <= 1'b0;
                            r_drop           <= r_drop + t_cnt'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (i_cmd.commit) begin
                r_live <= n_live;
                if (r_op == rtae_pkg::OP_ADD) begin
                    r_valid[n_wslot] <= 1'b1;
                end
            end

            // A new operation may start in the commit cycle; trackers restart.
            if (i_cmd.start) begin
                r_idx       <= '0;
                r_found     <= 1'b0;
                r_hit       <= 1'b0;
                r_slot      <= '0;
                r_have_free <= 1'b0;
                r_free      <= '0;
                r_old       <= '0;
                r_max_age   <= '0;
                r_drop      <= '0;
            end
        end
    end

    assign o_done           = r_done;
    assign o_hit            = r_o_hit;
    assign o_found_next_hop = r_o_nh;
    assign o_found_cost     = r_o_cost;
    assign o_found_hops     = r_o_hops;
    assign o_slot_index     = r_o_slot;
    assign o_removed_count  = r_o_removed;
    assign o_entry_count    = r_o_count;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe held for more than one cycle");

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= t_cnt'(ROUTE_ENTRIES))
        else $error("live count exceeds table size");

    a_no_eval_at_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !r_q_ok)
        else $error("scan stage still active during commit");

endmodule

// ===== src/route_table_age_evict_top.sv =====
// Top level of the route table with age based eviction.
// Instantiates rtae_ctrl and rtae_dpath; depends on rtae_pkg.
//
// Every operation scans all ROUTE_ENTRIES slots through the single registered read port of
// the entry memory, one slot per cycle. After the accept the controller scans, drains and
// commits, and o_done is registered from the commit. A new operation is accepted only once
// the scan and drain are through; the result port cannot be stalled.
// Synchronous active-low reset clears all valid marks, the live count and the controller,
// and loads the route timeout with 300000; entry contents are left unset.
module route_table_age_evict_top #(
    parameter int ROUTE_ENTRIES = 32,
    parameter int ADDR_BITS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command channel: a beat is taken when i_start is high and o_busy is low.
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_dest_addr,
    input  logic [15:0] i_hop_addr,
    input  logic [15:0] i_link_cost,
    input  logic [7:0]  i_hop_count,
    input  logic [31:0] i_time_now,
    // Configuration channel for the route timeout.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    // Result beat, valid for exactly one cycle while o_done is high.
    output logic        o_done,
    output logic        o_hit,
    output logic [15:0] o_found_next_hop,
    output logic [15:0] o_found_cost,
    output logic [7:0]  o_found_hops,
    output logic [4:0]  o_slot_index,
    output logic [5:0]  o_removed_count,
    output logic [5:0]  o_entry_count
);

    rtae_pkg::t_cmd  w_cmd;
    rtae_pkg::t_stat w_stat;

    // The controller sequences accept, scan, drain and commit.
    rtae_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // The datapath holds the table and evaluates one slot per cycle during the scan.
    rtae_dpath #(
        .ROUTE_ENTRIES (ROUTE_ENTRIES),
        .ADDR_BITS     (ADDR_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_op             (i_op),
        .i_dest_addr      (i_dest_addr),
        .i_hop_addr       (i_hop_addr),
        .i_link_cost      (i_link_cost),
        .i_hop_count      (i_hop_count),
        .i_time_now       (i_time_now),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_hit            (o_hit),
        .o_found_next_hop (o_found_next_hop),
        .o_found_cost     (o_found_cost),
        .o_found_hops     (o_found_hops),
        .o_slot_index     (o_slot_index),
        .o_removed_count  (o_removed_count),
        .o_entry_count    (o_entry_count)
    );

endmodule

// ===== tb/route_table_age_evict_chk.sv =====
// Scoreboard for the route table with age based eviction: it mirrors the table, predicts
// one result beat per accepted command and compares the result port field by field.
// Depends on rtae_pkg for the operation codes.
module route_table_age_evict_chk #(
    parameter int ROUTE_ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_dest_addr,
    input  logic [15:0] i_hop_addr,
    input  logic [15:0] i_link_cost,
    input  logic [7:0]  i_hop_count,
    input  logic [31:0] i_time_now,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_done,
    input  logic        i_hit,
    input  logic [15:0] i_found_next_hop,
    input  logic [15:0] i_found_cost,
    input  logic [7:0]  i_found_hops,
    input  logic [4:0]  i_slot_index,
    input  logic [5:0]  i_removed_count,
    input  logic [5:0]  i_entry_count,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked,
    output int          o_hits,
    output int          o_replaced,
    output int          o_dropped
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] RESET_TIMEOUT = 32'd300000;
    localparam int          REPORT_CAP    = 50;

    typedef struct packed {
        logic        hit;
        logic [15:0] via;
        logic [15:0] cost;
        logic [7:0]  hops;
        logic [4:0]  slot;
        logic [5:0]  removed;
        logic [5:0]  count;
    } t_route_result;

    // Mirror of the route table and its timeout register.
    logic        tbl_valid [ROUTE_ENTRIES];
    logic [15:0] tbl_dest  [ROUTE_ENTRIES];
    logic [15:0] tbl_hop   [ROUTE_ENTRIES];
    logic [15:0] tbl_cost  [ROUTE_ENTRIES];
    logic [7:0]  tbl_hops  [ROUTE_ENTRIES];
    logic [31:0] tbl_stamp [ROUTE_ENTRIES];
    int          route_live;
    logic [31:0] route_timeout;

    t_route_result route_results_due [$];
    t_route_result predicted;
    t_route_result arrived;

    int error_total    = 0;
    int checked_total  = 0;
    int hit_total      = 0;
    int replaced_total = 0;
    int dropped_total  = 0;

    assign o_errors   = error_total;
    assign o_checked  = checked_total;
    assign o_hits     = hit_total;
    assign o_replaced = replaced_total;
    assign o_dropped  = dropped_total;

    initial o_pending = 0;

    task automatic drop_route();
        if (route_live > 0)
            route_live--;
    endtask

    task automatic apply_route_op(input rtae_pkg::t_op op, input logic [15:0] dest,
                                  input logic [15:0] hop, input logic [15:0] cost,
                                  input logic [7:0] hops, input logic [31:0] now,
                                  output t_route_result res);
        bit          found;
        bit          free_found;
        int          victim;
        int          removed;
        logic [31:0] age;
        logic [31:0] oldest_age;
        res        = '0;
        found      = 1'b0;
        free_found = 1'b0;
        victim     = 0;
        removed    = 0;
        oldest_age = '0;
        case (op)
            rtae_pkg::OP_LOOKUP: begin
                // Only the first matching entry is considered; an aged one is dropped.
                for (int i = 0; i < ROUTE_ENTRIES && !found; i++) begin
                    if (tbl_valid[i] && tbl_dest[i] == dest) begin
                        found = 1'b1;
                        age   = now - tbl_stamp[i];
                        if (age > route_timeout) begin
                            tbl_valid[i] = 1'b0;
                            drop_route();
                        end else begin
                            res.hit  = 1'b1;
                            res.via  = tbl_hop[i];
                            res.cost = tbl_cost[i];
                            res.hops = tbl_hops[i];
                            res.slot = 5'(i);
                            hit_total++;
                        end
                    end
                end
            end
            rtae_pkg::OP_ADD: begin
                for (int i = 0; i < ROUTE_ENTRIES && !found; i++) begin
                    if (tbl_valid[i] && tbl_dest[i] == dest) begin
                        found  = 1'b1;
                        victim = i;
                    end
                end
                if (!found) begin
                    // First free slot, else the oldest one with the last slot winning ties.
                    for (int i = 0; i < ROUTE_ENTRIES && !free_found; i++) begin
                        if (!tbl_valid[i]) begin
                            free_found = 1'b1;
                            victim     = i;
                        end else begin
                            age = now - tbl_stamp[i];
                            if (age >= oldest_age) begin
                                oldest_age = age;
                                victim     = i;
                            end
                        end
                    end
                    if (free_found)
                        route_live++;
                    else
                        replaced_total++;
                    tbl_valid[victim] = 1'b1;
                    tbl_dest[victim]  = dest;
                end
                tbl_hop[victim]   = hop;
                tbl_cost[victim]  = cost;
                tbl_hops[victim]  = hops;
                tbl_stamp[victim] = now;
                res.hit  = 1'b1;
                res.via  = hop;
                res.cost = cost;
                res.hops = hops;
                res.slot = 5'(victim);
            end
            rtae_pkg::OP_REMOVE: begin
                for (int i = 0; i < ROUTE_ENTRIES; i++) begin
                    if (tbl_valid[i] && tbl_hop[i] == hop) begin
                        tbl_valid[i] = 1'b0;
                        drop_route();
                        removed++;
                    end
                end
            end
            default: begin
                for (int i = 0; i < ROUTE_ENTRIES; i++) begin
                    age = now - tbl_stamp[i];
                    if (tbl_valid[i] && age > route_timeout) begin
                        tbl_valid[i] = 1'b0;
                        drop_route();
                        removed++;
                    end
                end
            end
        endcase
        dropped_total += removed;
        res.removed = 6'(removed);
        res.count   = 6'(route_live);
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            error_total++;
            if (error_total <= REPORT_CAP)
                $display("%0t: result %0d, %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, checked_total, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ROUTE_ENTRIES; i++)
                tbl_valid[i] = 1'b0;
            route_live    = 0;
            route_timeout = RESET_TIMEOUT;
            route_results_due.delete();
            o_pending <= 0;
        end else begin
            if (i_done !== 1'b0) begin
                if (route_results_due.size() == 0) begin
                    error_total++;
                    if (error_total <= REPORT_CAP)
                        $display("%0t: result beat with no command outstanding", $time);
                end else begin
                    predicted = route_results_due.pop_front();
                    arrived   = '{i_hit, i_found_next_hop, i_found_cost, i_found_hops,
                                  i_slot_index, i_removed_count, i_entry_count};
                    compare_field("hit", 32'(predicted.hit), 32'(arrived.hit));
                    compare_field("found_next_hop", 32'(predicted.via), 32'(arrived.via));
                    compare_field("found_cost", 32'(predicted.cost), 32'(arrived.cost));
                    compare_field("found_hops", 32'(predicted.hops), 32'(arrived.hops));
                    compare_field("slot_index", 32'(predicted.slot), 32'(arrived.slot));
                    compare_field("removed_count", 32'(predicted.removed),
                                  32'(arrived.removed));
                    compare_field("entry_count", 32'(predicted.count), 32'(arrived.count));
                    checked_total++;
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                route_timeout = i_cfg_data;
            if (i_start && !i_busy) begin
                apply_route_op(rtae_pkg::t_op'(i_op), i_dest_addr, i_hop_addr, i_link_cost,
                               i_hop_count, i_time_now, predicted);
                route_results_due.push_back(predicted);
            end
            o_pending <= route_results_due.size();
        end
    end

endmodule

// ===== tb/route_table_age_evict_top_tb.sv =====
// Testbench top for the route table with age based eviction: clock, reset, command and
// timeout stimulus, and the final verdict. Depends on rtae_pkg, route_table_age_evict_top
// and the scoreboard route_table_age_evict_chk.
module route_table_age_evict_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ROUTE_ENTRIES = 32;
    localparam int          ADDR_BITS     = 16;
    localparam logic [31:0] RESET_TIMEOUT = 32'd300000;
    localparam int          PHASES        = 6;
    localparam int          PHASE_ITEMS   = 280;
    localparam int          DEST_POOL     = 40;
    localparam int          HOP_POOL      = 6;
    localparam int          CYCLE_LIMIT   = 1000000;

    logic        i_clk;
    logic        i_rst_n          = 1'b0;
    logic        i_start          = 1'b0;
    logic [1:0]  i_op             = '0;
    logic [15:0] i_dest_addr      = '0;
    logic [15:0] i_hop_addr       = '0;
    logic [15:0] i_link_cost      = '0;
    logic [7:0]  i_hop_count      = '0;
    logic [31:0] i_time_now       = '0;
    logic        i_cfg_valid      = 1'b0;
    logic [31:0] i_cfg_data       = '0;
    logic        o_busy;
    logic        o_cfg_ready;
    logic        o_done;
    logic        o_hit;
    logic [15:0] o_found_next_hop;
    logic [15:0] o_found_cost;
    logic [7:0]  o_found_hops;
    logic [4:0]  o_slot_index;
    logic [5:0]  o_removed_count;
    logic [5:0]  o_entry_count;

    int chk_errors;
    int chk_pending;
    int chk_checked;
    int chk_hits;
    int chk_replaced;
    int chk_dropped;

    // Stimulus bookkeeping: the running millisecond clock, the timeout the block holds,
    // and small address pools so that lookups, refreshes and removals find their targets.
    logic [31:0] clock_ms;
    logic [31:0] route_timeout_now = RESET_TIMEOUT;
    logic [15:0] dest_pool [DEST_POOL];
    logic [15:0] hop_pool  [HOP_POOL];
    bit          steady_run  = 1'b0;
    int          cmd_total   = 0;
    int          cycle_count = 0;

    route_table_age_evict_top #(
        .ROUTE_ENTRIES (ROUTE_ENTRIES),
        .ADDR_BITS     (ADDR_BITS)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_op             (i_op),
        .i_dest_addr      (i_dest_addr),
        .i_hop_addr       (i_hop_addr),
        .i_link_cost      (i_link_cost),
        .i_hop_count      (i_hop_count),
        .i_time_now       (i_time_now),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_hit            (o_hit),
        .o_found_next_hop (o_found_next_hop),
        .o_found_cost     (o_found_cost),
        .o_found_hops     (o_found_hops),
        .o_slot_index     (o_slot_index),
        .o_removed_count  (o_removed_count),
        .o_entry_count    (o_entry_count)
    );

    route_table_age_evict_chk #(
        .ROUTE_ENTRIES (ROUTE_ENTRIES)
    ) u_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .i_busy           (o_busy),
        .i_op             (i_op),
        .i_dest_addr      (i_dest_addr),
        .i_hop_addr       (i_hop_addr),
        .i_link_cost      (i_link_cost),
        .i_hop_count      (i_hop_count),
        .i_time_now       (i_time_now),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_done           (o_done),
        .i_hit            (o_hit),
        .i_found_next_hop (o_found_next_hop),
        .i_found_cost     (o_found_cost),
        .i_found_hops     (o_found_hops),
        .i_slot_index     (o_slot_index),
        .i_removed_count  (o_removed_count),
        .i_entry_count    (o_entry_count),
        .o_errors         (chk_errors),
        .o_pending        (chk_pending),
        .o_checked        (chk_checked),
        .o_hits           (chk_hits),
        .o_replaced       (chk_replaced),
        .o_dropped        (chk_dropped)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk)
        cycle_count <= cycle_count + 1;

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);
        $display("FAIL route_table_age_evict_top");
        $finish;
    end

    // Idle time before a command. Most gaps are short, some span a good part of the
    // scan so that a new command shows up at every point of it, and a few are long.
    // During steady stretches commands follow back to back.
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_run || roll < 45)
            return 0;
        if (roll < 80)
            return $urandom_range(1, 3);
        if (roll < 95)
            return $urandom_range(4, 40);
        return $urandom_range(41, 150);
    endfunction

    // Presents one command beat and returns at the edge that takes it. Start stays high
    // across back-to-back beats, so it gets a single assignment per time step.
    task automatic send_route_cmd(input rtae_pkg::t_op op, input logic [15:0] dest,
                                  input logic [15:0] hop, input logic [15:0] cost,
                                  input logic [7:0] hops, input logic [31:0] now);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start     <= 1'b1;
        i_op        <= op;
        i_dest_addr <= dest;
        i_hop_addr  <= hop;
        i_link_cost <= cost;
        i_hop_count <= hops;
        i_time_now  <= now;
        @(posedge i_clk);
        while (o_busy !== 1'b0)
            @(posedge i_clk);
        cmd_total++;
    endtask

    // Drops start and waits until every predicted result beat has come back. The
    // scoreboard updates its count at the edge, so the first look comes after an edge has passed.
    task automatic drain_results();
        i_start <= 1'b0;
        do
            @(posedge i_clk);
        while (chk_pending != 0);
    endtask

    // Writes the route timeout; only called while the block is idle.
    task automatic write_timeout(input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (o_cfg_ready !== 1'b1);
        i_cfg_valid       <= 1'b0;
        route_timeout_now  = value;
    endtask

    // Hand-picked sequence under the reset timeout. The base time sits just below the
    // 32-bit wrap so that ages are computed across it. It covers a lookup on an empty
    // table, adds with all-zero and all-one fields, a refresh in place, a lookup whose age
    // equals the timeout (still live) and one past it (dropped, reported as a miss),
    // reuse of the freed slot, removal by next hop with and without matches, and expiry
    // of some, all and none of the entries.
    task automatic run_directed();
        logic [31:0] base;
        base = 32'hFFFF_FF00;
        send_route_cmd(rtae_pkg::OP_LOOKUP, 16'h1234, 16'h0000, 16'h0000, 8'h00, base);
        send_route_cmd(rtae_pkg::OP_EXPIRE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, base);
        send_route_cmd(rtae_pkg::OP_ADD,    16'h1234, 16'h0001, 16'd10,   8'd3,  base);
        send_route_cmd(rtae_pkg::OP_ADD,    16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, base);
        send_route_cmd(rtae_pkg::OP_ADD,    16'h0000, 16'h0000, 16'h0000, 8'h00, base);
        send_route_cmd(rtae_pkg::OP_LOOKUP, 16'h1234, 16'h0000, 16'h0000, 8'h00,
                       base + 32'h200);
        send_route_cmd(rtae_pkg::OP_ADD,    16'h1234, 16'h0001, 16'd20,   8'd4,
                       base + 32'h200);
        send_route_cmd(rtae_pkg::OP_ADD,    16'h5555, 16'h0001, 16'd7,    8'd1,
                       base + 32'h200);
        send_route_cmd(rtae_pkg::OP_LOOKUP, 16'hFFFF, 16'h0000, 16'h0000, 8'h00,
                       base + RESET_TIMEOUT);
        send_route_cmd(rtae_pkg::OP_LOOKUP, 16'hFFFF, 16'h0000, 16'h0000, 8'h00,
                       base + RESET_TIMEOUT + 32'd1);
        send_route_cmd(rtae_pkg::OP_LOOKUP, 16'hFFFF, 16'h0000, 16'h0000, 8'h00,
                       base + RESET_TIMEOUT + 32'd1);
        send_route_cmd(rtae_pkg::OP_ADD,    16'hAAAA, 16'h00FF, 16'h8000, 8'h80,
                       base + RESET_TIMEOUT + 32'd1);
        send_route_cmd(rtae_pkg::OP_REMOVE, 16'hFFFF, 16'h0001, 16'hFFFF, 8'hFF, base);
        send_route_cmd(rtae_pkg::OP_REMOVE, 16'h0000, 16'hBEEF, 16'h0000, 8'h00, base);
        send_route_cmd(rtae_pkg::OP_EXPIRE, 16'h0000, 16'h0000, 16'h0000, 8'h00,
                       base + RESET_TIMEOUT + 32'd1);
        send_route_cmd(rtae_pkg::OP_LOOKUP, 16'hAAAA, 16'h0000, 16'h0000, 8'h00,
                       base + RESET_TIMEOUT + 32'd1);
        send_route_cmd(rtae_pkg::OP_ADD,    16'h0F0F, 16'h1111, 16'h7FFF, 8'h7F,
                       32'h0000_0000);
        send_route_cmd(rtae_pkg::OP_EXPIRE, 16'h0000, 16'h0000, 16'h0000, 8'h00,
                       base + 2 * RESET_TIMEOUT + 32'd2);
        send_route_cmd(rtae_pkg::OP_EXPIRE, 16'h0000, 16'h0000, 16'h0000, 8'h00,
                       32'hFFFF_FFFF);
        send_route_cmd(rtae_pkg::OP_REMOVE, 16'h0000, 16'hFFFF, 16'h0000, 8'h00,
                       32'hFFFF_FFFF);
    endtask

    // One random command. Most are well formed: destinations and next hops come from the
    // pools and time moves forward, often not at all so that equal stamps (and so ties in
    // the choice of the oldest slot) are common, sometimes by a whole timeout so that
    // everything ages. Some lookups and expiries probe right at the timeout boundary of
    // entries stamped at the current time. A few commands are fully random noise.
    task automatic send_random_cmd();
        int            pick;
        int            pace;
        rtae_pkg::t_op op;
        logic [15:0]   dest;
        logic [15:0]   hop;
        logic [15:0]   cost;
        logic [7:0]    hops;
        logic [31:0]   time_ms;
        pick = $urandom_range(0, 99);
        pace = $urandom_range(0, 99);
        dest = dest_pool[$urandom_range(0, DEST_POOL - 1)];
        hop  = hop_pool[$urandom_range(0, HOP_POOL - 1)];
        cost = 16'($urandom);
        hops = 8'($urandom);
        if (pace >= 93)
            clock_ms = clock_ms + route_timeout_now + 32'($urandom_range(0, 3));
        else if (pace >= 35)
            clock_ms = clock_ms + 32'($urandom_range(1, (route_timeout_now >> 4) + 1));
        time_ms = clock_ms;
        if (pick < 4) begin
            op      = rtae_pkg::t_op'($urandom_range(0, 3));
            dest    = 16'($urandom);
            hop     = 16'($urandom);
            time_ms = $urandom;
        end else if (pick < 44) begin
            op = rtae_pkg::OP_ADD;
        end else if (pick < 78) begin
            op = rtae_pkg::OP_LOOKUP;
        end else if (pick < 89) begin
            op = rtae_pkg::OP_REMOVE;
        end else begin
            op = rtae_pkg::OP_EXPIRE;
        end
        if (pick >= 4 && (op == rtae_pkg::OP_LOOKUP || op == rtae_pkg::OP_EXPIRE) &&
            $urandom_range(0, 99) < 15)
            time_ms = clock_ms + route_timeout_now - 32'd1 + 32'($urandom_range(0, 2));
        send_route_cmd(op, dest, hop, cost, hops, time_ms);
    endtask

    initial begin
        logic [31:0] timeout_plan [PHASES];
        int          directed_total;
        // The first phase keeps the reset timeout; the others cover both extremes, a
        // short timeout, a random one and a return to the reset value.
        timeout_plan = '{RESET_TIMEOUT, 32'hFFFF_FFFF, 32'd0, 32'd64, 32'd0, RESET_TIMEOUT};
        timeout_plan[4] = $urandom_range(500, 4000000);
        dest_pool[0] = 16'h0000;
        dest_pool[1] = 16'hFFFF;
        for (int i = 2; i < DEST_POOL; i++)
            dest_pool[i] = 16'($urandom);
        hop_pool[0] = 16'h0000;
        hop_pool[1] = 16'hFFFF;
        for (int i = 2; i < HOP_POOL; i++)
            hop_pool[i] = 16'($urandom);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        drain_results();
        directed_total = cmd_total;

        clock_ms = $urandom;
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0)
                write_timeout(timeout_plan[phase]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // Every fourth stretch of fifty commands runs without idle gaps.
                steady_run = ((k / 50) % 4) == 3;
                send_random_cmd();
            end
            drain_results();
        end

        // Let a full scan pass so that any stray result beat would still be seen.
        repeat (ROUTE_ENTRIES + 8) @(posedge i_clk);

        $display("Ran %0d commands (%0d hand-picked) under %0d timeout settings; %0d results",
                 cmd_total, directed_total, PHASES, chk_checked);
        $display("checked, %0d lookup hits, %0d oldest-slot replacements, %0d routes dropped.",
                 chk_hits, chk_replaced, chk_dropped);
        if (chk_errors == 0 && chk_pending == 0)
            $display("PASS route_table_age_evict_top");
        else
            $display("FAIL route_table_age_evict_top");
        $finish;
    end

endmodule
